// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the one-wire bus master RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk edge outside reset.
`define OWM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define OWM_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/owm_pkg.sv -----
// ---------------------------------------------------------------------------
// One-wire bus master package
// Types, codes and constants shared by the bus master modules.
// ---------------------------------------------------------------------------
`default_nettype none

package owm_pkg;

  localparam int unsigned TICK_W = 8;
  localparam logic [TICK_W-1:0] RECOVERY_TICKS = 8'd13;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_RESET = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_RST_LOW   = 4'd1,
    PH_RST_REL   = 4'd2,
    PH_PRES_WAIT = 4'd3,
    PH_PRES_LOW  = 4'd4,
    PH_WR_LOW    = 4'd5,
    PH_WR_HIGH   = 4'd6,
    PH_RD_LOW    = 4'd7,
    PH_RD_REL    = 4'd8,
    PH_RD_REC    = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_PRES_WAIT     = 3'd2,
    REG_PRES_LOW      = 3'd3,
    REG_WRITE_SHORT   = 3'd4,
    REG_WRITE_LONG    = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_SAMPLE   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] tx_byte;
    logic       bus_level;
  } in_item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       absent;
    logic [7:0] rx_byte;
  } out_item_t;

  typedef struct packed {
    logic [TICK_W-1:0] reset_low_ticks;
    logic [TICK_W-1:0] reset_release_ticks;
    logic [TICK_W-1:0] presence_wait_limit;
    logic [TICK_W-1:0] presence_low_limit;
    logic [TICK_W-1:0] write_short_ticks;
    logic [TICK_W-1:0] write_long_ticks;
    logic [TICK_W-1:0] read_low_ticks;
    logic [TICK_W-1:0] read_sample_ticks;
  } owm_cfg_t;

  localparam owm_cfg_t CFG_RESET = '{
    reset_low_ticks:     8'd125,
    reset_release_ticks: 8'd4,
    presence_wait_limit: 8'd50,
    presence_low_limit:  8'd60,
    write_short_ticks:   8'd1,
    write_long_ticks:    8'd15,
    read_low_ticks:      8'd2,
    read_sample_ticks:   8'd3
  };

endpackage

`default_nettype wire

// ----- rtl/owm_fsm.sv -----
// ---------------------------------------------------------------------------
// One-wire bus master sequencer
// Holds the slot state and computes the result of the current tick.
// ---------------------------------------------------------------------------
`default_nettype none

module owm_fsm (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               step,
  input  wire owm_pkg::in_item_t  item,
  input  wire owm_pkg::owm_cfg_t  cfg,
  output owm_pkg::out_item_t      result
);
  import owm_pkg::*;

  phase_t            phase_r, phase_nxt, phase_cur;
  logic [TICK_W-1:0] tick_r, tick_nxt, tick_cur, tick_inc, limit;
  logic [2:0]        bit_r, bit_nxt, bit_cur;
  logic [7:0]        tx_r, tx_nxt, tx_cur;
  logic [7:0]        rx_r, rx_nxt, rx_cur;
  logic              absent_r, absent_nxt;
  logic              drive, finish, one, limit_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bit_r    <= '0;
      tx_r     <= '0;
      rx_r     <= '0;
      absent_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bit_r    <= bit_nxt;
      tx_r     <= tx_nxt;
      rx_r     <= rx_nxt;
      absent_r <= absent_nxt;
    end
  end

  always_comb begin
    phase_cur = phase_r;
    tick_cur  = tick_r;
    bit_cur   = bit_r;
    tx_cur    = tx_r;
    rx_cur    = rx_r;
    if (phase_r == PH_IDLE) begin
      unique case (cmd_t'(item.cmd))
        CMD_RESET: begin
          phase_cur = PH_RST_LOW;
          tick_cur  = '0;
        end
        CMD_WRITE: begin
          phase_cur = PH_WR_LOW;
          tick_cur  = '0;
          tx_cur    = item.tx_byte;
          bit_cur   = '0;
        end
        CMD_READ: begin
          phase_cur = PH_RD_LOW;
          tick_cur  = '0;
          rx_cur    = '0;
          bit_cur   = '0;
        end
        default: ;
      endcase
    end
  end

  assign one      = tx_cur[0];
  assign tick_inc = tick_cur + TICK_W'(1);

  always_comb begin
    unique case (phase_cur)
      PH_RST_LOW:   limit = cfg.reset_low_ticks;
      PH_RST_REL:   limit = cfg.reset_release_ticks;
      PH_PRES_WAIT: limit = cfg.presence_wait_limit;
      PH_PRES_LOW:  limit = cfg.presence_low_limit;
      PH_WR_LOW:    limit = one ? cfg.write_short_ticks : cfg.write_long_ticks;
      PH_WR_HIGH:   limit = one ? cfg.write_long_ticks : cfg.write_short_ticks;
      PH_RD_LOW:    limit = cfg.read_low_ticks;
      PH_RD_REL:    limit = cfg.read_sample_ticks;
      PH_RD_REC:    limit = RECOVERY_TICKS;
      default:      limit = RECOVERY_TICKS;
    endcase
  end

  assign limit_hit = tick_inc >= limit;

  always_comb begin
    phase_nxt  = phase_cur;
    tick_nxt   = tick_inc;
    bit_nxt    = bit_cur;
    tx_nxt     = tx_cur;
    rx_nxt     = rx_cur;
    absent_nxt = absent_r;
    drive      = 1'b0;
    finish     = 1'b0;
    unique case (phase_cur)
      PH_IDLE: begin
        tick_nxt = tick_cur;
      end
      PH_RST_LOW: begin
        drive = 1'b1;
        if (limit_hit) begin
          phase_nxt = PH_RST_REL;
          tick_nxt  = '0;
        end
      end
      PH_RST_REL: begin
        if (limit_hit) begin
          phase_nxt = PH_PRES_WAIT;
          tick_nxt  = '0;
        end
      end
      PH_PRES_WAIT: begin
        if (!item.bus_level) begin
          phase_nxt = PH_PRES_LOW;
          tick_nxt  = '0;
        end else if (limit_hit) begin
          absent_nxt = 1'b1;
          finish     = 1'b1;
        end
      end
      PH_PRES_LOW: begin
        if (item.bus_level) begin
          tick_nxt   = tick_cur;
          absent_nxt = 1'b0;
          finish     = 1'b1;
        end else if (limit_hit) begin
          absent_nxt = 1'b1;
          finish     = 1'b1;
        end
      end
      PH_WR_LOW: begin
        drive = 1'b1;
        if (limit_hit) begin
          phase_nxt = PH_WR_HIGH;
          tick_nxt  = '0;
        end
      end
      PH_WR_HIGH: begin
        if (limit_hit) begin
          tx_nxt = {1'b0, tx_cur[7:1]};
          if (bit_cur == 3'd7) begin
            bit_nxt = '0;
            finish  = 1'b1;
          end else begin
            bit_nxt   = bit_cur + 3'd1;
            phase_nxt = PH_WR_LOW;
            tick_nxt  = '0;
          end
        end
      end
      PH_RD_LOW: begin
        drive = 1'b1;
        if (limit_hit) begin
          phase_nxt = PH_RD_REL;
          tick_nxt  = '0;
        end
      end
      PH_RD_REL: begin
        if (limit_hit) begin
          phase_nxt = PH_RD_REC;
          tick_nxt  = '0;
        end
      end
      PH_RD_REC: begin
        if (tick_cur == '0) begin
          rx_nxt = {item.bus_level, rx_cur[7:1]};
        end
        if (limit_hit) begin
          if (bit_cur == 3'd7) begin
            bit_nxt = '0;
            finish  = 1'b1;
          end else begin
            bit_nxt   = bit_cur + 3'd1;
            phase_nxt = PH_RD_LOW;
            tick_nxt  = '0;
          end
        end
      end
      default: begin
        tick_nxt = tick_cur;
        finish   = 1'b1;
      end
    endcase
    if (finish) begin
      phase_nxt = PH_IDLE;
      tick_nxt  = '0;
    end
  end

  assign result.drive_low = drive;
  assign result.busy_res  = (phase_cur != PH_IDLE);
  assign result.done_res  = finish;
  assign result.absent    = absent_nxt;
  assign result.rx_byte   = rx_nxt;

endmodule

`default_nettype wire

// ----- rtl/one_wire_bus_master.sv -----
// One transfer on the input channel is one 4 us bus tick carrying the sampled
// bus level, and a command when the master is idle. Every accepted tick yields
// exactly one result transfer, registered in the output buffer. The slot
// sequencer updates its state once per tick, so a tick can be accepted in
// every cycle; a two-entry output buffer keeps one more tick flowing while a
// result waits, and in_stall rises only when both entries hold.
// ---------------------------------------------------------------------------
// One-wire bus master
// Reset/presence, byte write and byte read sequencing on a tick stream.
// ---------------------------------------------------------------------------
`default_nettype none

module one_wire_bus_master (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire owm_pkg::in_item_t      in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output owm_pkg::out_item_t          out_data,
  input  wire logic                   cfg_we,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [7:0]             cfg_wdata
);
  import owm_pkg::*;

  `include "assert_macros.svh"

  owm_cfg_t  cfg_r;
  out_item_t result;
  out_item_t out_data_r, skid_data_r;
  logic      out_valid_r, skid_valid_r;
  logic      in_take, out_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_RESET_LOW:     cfg_r.reset_low_ticks     <= cfg_wdata;
        REG_RESET_RELEASE: cfg_r.reset_release_ticks <= cfg_wdata;
        REG_PRES_WAIT:     cfg_r.presence_wait_limit <= cfg_wdata;
        REG_PRES_LOW:      cfg_r.presence_low_limit  <= cfg_wdata;
        REG_WRITE_SHORT:   cfg_r.write_short_ticks   <= cfg_wdata;
        REG_WRITE_LONG:    cfg_r.write_long_ticks    <= cfg_wdata;
        REG_READ_LOW:      cfg_r.read_low_ticks      <= cfg_wdata;
        REG_READ_SAMPLE:   cfg_r.read_sample_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = skid_valid_r;
  assign in_take  = in_valid && !skid_valid_r;
  assign out_take = out_valid_r && !out_stall;

  owm_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_take),
    .item   (in_data),
    .cfg    (cfg_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_take) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_take;
      end
    end else if (in_take) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_take) begin
      out_data_r <= skid_valid_r ? skid_data_r : result;
    end
    if (out_valid_r && !out_take && in_take) begin
      skid_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `OWM_ASSERT(a_skid_needs_out, skid_valid_r |-> out_valid_r, "skid entry without output entry")
  `OWM_ASSERT(a_done_is_busy, out_valid_r && out_data_r.done_res |-> out_data_r.busy_res, "done without busy")
  `OWM_ASSERT(a_drive_is_busy, out_valid_r && out_data_r.drive_low |-> out_data_r.busy_res, "bus driven while idle")
  `OWM_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r && !skid_valid_r, "buffer not empty after reset")

endmodule

`default_nettype wire

// ----- sim/one_wire_bus_master_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// One-wire bus master testbench
// Streams bus ticks into the master and checks every status transfer against
// a cycle-level model of the reset/presence, byte write and byte read
// sequencers, or against a fixed value on pinned rows. A directed table runs
// first, followed by random phases, each with its own timing register setting.
// ---------------------------------------------------------------------------

module one_wire_bus_master_tb;
  import owm_pkg::*;

  localparam logic [7:0] RECOVERY = 8'd13;
  localparam int PLAN_LEN = 9;
  localparam int RANDOM_PHASES = 4;
  localparam int PHASE_ITEMS = 50;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef enum int {MIX_ZERO, MIX_MAX, MIX_SHORT} cfg_mix_t;

  typedef struct packed {
    in_item_t  item;
    logic [8:0] reps;
    logic       pinned;
    out_item_t  want;
  } step_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [7:0] cfg_wdata = '0;

  one_wire_bus_master uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // Model state of the sequencer.
  phase_t     ph = PH_IDLE;
  logic [7:0] ticks = '0;
  logic [2:0] bitn = '0;
  logic [7:0] tx_sr = '0;
  logic [7:0] rx_sr = '0;
  logic       no_device = 1'b0;
  logic [7:0] regs [8];

  out_item_t  pending_status [$];
  step_row_t  plan [PLAN_LEN];
  int         bad_fields = 0;
  int         quiet_cycles = 0;
  int         hold_left = 0;
  int         bias = 2;
  bit         calm = 1'b0;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic line_level();
    if (bias == 2) return 1'($urandom_range(0, 1));
    return ($urandom_range(0, 7) == 0) ? (bias != 0) : (bias == 0);
  endfunction

  function automatic logic slot_elapsed(input logic [7:0] limit);
    ticks = ticks + 8'd1;
    return ticks >= limit;
  endfunction

  function automatic void enter_phase(input phase_t p);
    ph = p;
    ticks = '0;
  endfunction

  function automatic out_item_t predict_status(input in_item_t it);
    out_item_t res;
    logic fin;
    logic one;
    res = '0;
    fin = 1'b0;
    if (ph == PH_IDLE) begin
      if (it.cmd == CMD_RESET) begin
        enter_phase(PH_RST_LOW);
      end else if (it.cmd == CMD_WRITE) begin
        tx_sr = it.tx_byte;
        bitn = '0;
        enter_phase(PH_WR_LOW);
      end else if (it.cmd == CMD_READ) begin
        rx_sr = '0;
        bitn = '0;
        enter_phase(PH_RD_LOW);
      end
    end
    if (ph != PH_IDLE) begin
      res.busy_res = 1'b1;
      one = tx_sr[0];
      case (ph)
        PH_RST_LOW: begin
          res.drive_low = 1'b1;
          if (slot_elapsed(regs[REG_RESET_LOW])) enter_phase(PH_RST_REL);
        end
        PH_RST_REL: begin
          if (slot_elapsed(regs[REG_RESET_RELEASE])) enter_phase(PH_PRES_WAIT);
        end
        PH_PRES_WAIT: begin
          if (!it.bus_level) begin
            enter_phase(PH_PRES_LOW);
          end else if (slot_elapsed(regs[REG_PRES_WAIT])) begin
            no_device = 1'b1;
            fin = 1'b1;
          end
        end
        PH_PRES_LOW: begin
          if (it.bus_level) begin
            no_device = 1'b0;
            fin = 1'b1;
          end else if (slot_elapsed(regs[REG_PRES_LOW])) begin
            no_device = 1'b1;
            fin = 1'b1;
          end
        end
        PH_WR_LOW: begin
          res.drive_low = 1'b1;
          if (slot_elapsed(one ? regs[REG_WRITE_SHORT] : regs[REG_WRITE_LONG]))
            enter_phase(PH_WR_HIGH);
        end
        PH_WR_HIGH: begin
          if (slot_elapsed(one ? regs[REG_WRITE_LONG] : regs[REG_WRITE_SHORT])) begin
            tx_sr = tx_sr >> 1;
            if (bitn == 3'd7) begin
              bitn = '0;
              fin = 1'b1;
            end else begin
              bitn = bitn + 3'd1;
              enter_phase(PH_WR_LOW);
            end
          end
        end
        PH_RD_LOW: begin
          res.drive_low = 1'b1;
          if (slot_elapsed(regs[REG_READ_LOW])) enter_phase(PH_RD_REL);
        end
        PH_RD_REL: begin
          if (slot_elapsed(regs[REG_READ_SAMPLE])) enter_phase(PH_RD_REC);
        end
        PH_RD_REC: begin
          if (ticks == 8'd0) rx_sr = {it.bus_level, rx_sr[7:1]};
          if (slot_elapsed(RECOVERY)) begin
            if (bitn == 3'd7) begin
              bitn = '0;
              fin = 1'b1;
            end else begin
              bitn = bitn + 3'd1;
              enter_phase(PH_RD_LOW);
            end
          end
        end
        default: begin
          fin = 1'b1;
        end
      endcase
      if (fin) begin
        enter_phase(PH_IDLE);
        res.done_res = 1'b1;
      end
    end
    res.absent = no_device;
    res.rx_byte = rx_sr;
    return res;
  endfunction

  function automatic step_row_t row(input cmd_t c, input logic [7:0] tx, input logic bus,
                                    input int n);
    step_row_t s;
    s = '0;
    s.item = '{cmd: c, tx_byte: tx, bus_level: bus};
    s.reps = n[8:0];
    return s;
  endfunction

  function automatic step_row_t pinned(input cmd_t c, input logic [7:0] tx, input logic bus,
                                       input out_item_t want);
    step_row_t s;
    s = row(c, tx, bus, 1);
    s.pinned = 1'b1;
    s.want = want;
    return s;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      bad_fields++;
    end
  endfunction

  task automatic send_tick(input in_item_t it, input logic pin, input out_item_t want);
    out_item_t model;
    int gap;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model = predict_status(it);
    pending_status.push_back(pin ? want : model);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_tick();
    in_item_t it;
    it.tx_byte = 8'($urandom);
    it.cmd = 2'($urandom);
    if (ph == PH_IDLE) begin
      case ($urandom_range(0, 3))
        0: it.cmd = CMD_TICK;
        1: it.cmd = CMD_RESET;
        2: it.cmd = CMD_WRITE;
        default: it.cmd = CMD_READ;
      endcase
      if (it.cmd != CMD_TICK) bias = $urandom_range(0, 2);
    end
    it.bus_level = line_level();
    send_tick(it, 1'b0, '0);
  endtask

  // Finishes any running command, then waits for every status transfer.
  task automatic settle();
    in_item_t it;
    while (ph != PH_IDLE) begin
      it = '0;
      it.cmd = CMD_TICK;
      it.bus_level = line_level();
      send_tick(it, 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
  endtask

  task automatic load_regs(input cfg_mix_t mix);
    reg_idx_t r;
    logic [7:0] v;
    r = r.first();
    do begin
      case (mix)
        MIX_ZERO: v = 8'h00;
        MIX_MAX: v = (r == REG_RESET_RELEASE || r == REG_PRES_LOW) ? 8'hFF : 8'h01;
        default: v = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(7, 20))
                                                 : 8'($urandom_range(0, 6));
      endcase
      cfg_we <= 1'b1;
      cfg_index <= r;
      cfg_wdata <= v;
      @(posedge clk);
      regs[r] = v;
      r = r.next();
    end while (r != r.first());
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= 1'b0;
      hold_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_status.size() == 0) begin
        $error("status transfer with nothing expected");
        bad_fields++;
      end else begin
        want = pending_status.pop_front();
        check_field("drive_low", 8'(want.drive_low), 8'(out_data.drive_low));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        check_field("absent", 8'(want.absent), 8'(out_data.absent));
        check_field("rx_byte", want.rx_byte, out_data.rx_byte);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("one_wire_bus_master: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    regs[REG_RESET_LOW] = CFG_RESET.reset_low_ticks;
    regs[REG_RESET_RELEASE] = CFG_RESET.reset_release_ticks;
    regs[REG_PRES_WAIT] = CFG_RESET.presence_wait_limit;
    regs[REG_PRES_LOW] = CFG_RESET.presence_low_limit;
    regs[REG_WRITE_SHORT] = CFG_RESET.write_short_ticks;
    regs[REG_WRITE_LONG] = CFG_RESET.write_long_ticks;
    regs[REG_READ_LOW] = CFG_RESET.read_low_ticks;
    regs[REG_READ_SAMPLE] = CFG_RESET.read_sample_ticks;

    // Timing is at its reset values throughout this table.
    plan = '{
      pinned(CMD_TICK, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}),
      pinned(CMD_TICK, 8'hFF, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00}),
      row(CMD_RESET, 8'h00, 1'b1, 178),
      pinned(CMD_TICK, 8'h00, 1'b1, '{1'b0, 1'b1, 1'b1, 1'b1, 8'h00}),
      pinned(CMD_TICK, 8'h00, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00}),
      row(CMD_WRITE, 8'hA5, 1'b1, 1),
      row(CMD_READ, 8'h5A, 1'b0, 127),
      row(CMD_READ, 8'h00, 1'b1, 144),
      pinned(CMD_TICK, 8'h00, 1'b0, '{1'b0, 1'b0, 1'b0, 1'b1, 8'hFF})
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      repeat (plan[i].reps) send_tick(plan[i].item, plan[i].pinned, plan[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      settle();
      calm = ($urandom_range(0, 3) == 0);
      load_regs(p == 0 ? MIX_ZERO : (p == 1 ? MIX_MAX : MIX_SHORT));
      repeat (PHASE_ITEMS) random_tick();
    end

    settle();
    repeat (8) @(posedge clk);
    if (bad_fields == 0 && pending_status.size() == 0) begin
      $display("one_wire_bus_master: match");
    end else begin
      $display("one_wire_bus_master: mismatch");
    end
    $finish;
  end

endmodule
